// ===== sv/fdc_pkg.sv =====
package fdc_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 15;
  localparam int unsigned POS_W            = $clog2(MAX_PACKET_BYTES + 1);

  localparam int unsigned DUTY_W    = 7;
  localparam int unsigned PWM_W     = 16;
  localparam int unsigned RES_W     = 5;
  localparam int unsigned TIMEOUT_W = 20;
  localparam int unsigned ELAPSED_W = 21;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = TIMEOUT_W;
  localparam int unsigned OUT_W     = 32;

  localparam logic [DUTY_W-1:0]    DUTY_MAX    = DUTY_W'(100);
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [7:0]           CHAR_P      = 8'h50;
  localparam logic [7:0]           CHAR_ZERO   = 8'h30;
  localparam logic [7:0]           CHAR_NINE   = 8'h39;

  localparam logic [RES_W-1:0] RES_MIN   = RES_W'(1);
  localparam logic [RES_W-1:0] RES_MAX   = RES_W'(16);
  localparam logic [RES_W-1:0] RES_RESET = RES_W'(8);
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(1000);

  // floor(x / 100) = (x * DIV100_MUL) >> DIV100_SHIFT for every x below 2^23.
  localparam int unsigned SCALE_W      = 23;
  localparam int unsigned DIV100_SHIFT = 30;
  localparam int unsigned DIV100_W     = 24;
  localparam logic [DIV100_W-1:0] DIV100_MUL = DIV100_W'(10737419);

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_PWM_BITS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    EVT_NONE     = 2'd0,
    EVT_ACCEPT   = 2'd1,
    EVT_REJECT   = 2'd2,
    EVT_FAILSAFE = 2'd3
  } fdc_evt_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              failsafe;
    fdc_evt_t          evt;
  } fdc_status_t;

endpackage

// ===== sv/fdc_parse.sv =====
module fdc_parse import fdc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 req_type,
  input  logic [7:0]           packet_byte,
  input  logic                 last_byte,
  input  logic [TIMEOUT_W-1:0] timeout,
  output fdc_status_t          status
);

  logic [DUTY_W-1:0]    duty,  duty_next;
  logic                 fs,    fs_next;
  logic [ELAPSED_W-1:0] el,    el_next;
  logic [POS_W-1:0]     pos,   pos_next;
  logic [DUTY_W-1:0]    acc,   acc_next;
  logic                 seen,  seen_next;
  logic                 run,   run_next;
  logic                 hdr,   hdr_next;

  logic                 is_digit;
  logic [3:0]           dval;
  logic [9:0]           mac;
  logic [ELAPSED_W-1:0] el_inc;
  fdc_evt_t             evt;

  assign is_digit = (packet_byte >= CHAR_ZERO) && (packet_byte <= CHAR_NINE);
  assign dval     = 4'(packet_byte - CHAR_ZERO);
  assign mac      = ({3'b000, acc} * 10'd10) + {6'b000000, dval};
  assign el_inc   = (el != ELAPSED_MAX) ? el + ELAPSED_W'(1) : el;

  always_comb begin
    duty_next = duty;
    fs_next   = fs;
    el_next   = el;
    pos_next  = pos;
    acc_next  = acc;
    seen_next = seen;
    run_next  = run;
    hdr_next  = hdr;
    evt       = EVT_NONE;
    if (req_type == REQ_BYTE) begin
      if (pos < POS_W'(MAX_PACKET_BYTES)) begin
        if (pos == '0) begin
          hdr_next = (packet_byte == CHAR_P);
        end else if (run) begin
          if (is_digit) begin
            acc_next  = (mac > 10'(DUTY_MAX)) ? DUTY_MAX : mac[DUTY_W-1:0];
            seen_next = 1'b1;
          end else begin
            run_next = 1'b0;
          end
        end
        pos_next = pos + POS_W'(1);
      end
      if (last_byte) begin
        if (hdr_next && seen_next) begin
          duty_next = acc_next;
          el_next   = '0;
          fs_next   = 1'b0;
          evt       = EVT_ACCEPT;
        end else begin
          evt = EVT_REJECT;
        end
        pos_next  = '0;
        acc_next  = '0;
        seen_next = 1'b0;
        run_next  = 1'b1;
        hdr_next  = 1'b0;
      end
    end else begin
      el_next = el_inc;
      if (!fs && (el_inc > {1'b0, timeout})) begin
        duty_next = '0;
        fs_next   = 1'b1;
        evt       = EVT_FAILSAFE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty <= '0;
      fs   <= 1'b0;
      el   <= '0;
      pos  <= '0;
      acc  <= '0;
      seen <= 1'b0;
      run  <= 1'b1;
      hdr  <= 1'b0;
    end else if (en) begin
      duty <= duty_next;
      fs   <= fs_next;
      el   <= el_next;
      pos  <= pos_next;
      acc  <= acc_next;
      seen <= seen_next;
      run  <= run_next;
      hdr  <= hdr_next;
    end
  end

  assign status.duty     = duty_next;
  assign status.failsafe = fs_next;
  assign status.evt      = evt;

`ifndef SYNTHESIS
  a_acc_range: assert property (@(posedge clk) disable iff (rst) acc <= DUTY_MAX)
    else $error("Digit accumulator exceeds full duty.");
  a_fs_duty: assert property (@(posedge clk) disable iff (rst) fs |-> duty == '0)
    else $error("Duty is not zero while failsafe is active.");
  a_pos_cap: assert property (@(posedge clk) disable iff (rst)
      pos <= POS_W'(MAX_PACKET_BYTES))
    else $error("Byte position runs beyond the packet limit.");
  a_el_clear: assert property (@(posedge clk) disable iff (rst)
      en && status.evt == EVT_ACCEPT |=> el == '0 && !fs)
    else $error("Accepted packet did not clear the tick counter and failsafe.");
`endif

endmodule

// ===== sv/fdc_scale.sv =====
module fdc_scale import fdc_pkg::*; (
  input  logic [DUTY_W-1:0] duty,
  input  logic [RES_W-1:0]  res_bits,
  output logic [PWM_W-1:0]  pwm_level
);

  logic [RES_W-1:0]            bits;
  logic [SCALE_W-1:0]          scaled;
  logic [SCALE_W+DIV100_W-1:0] prod;

  always_comb begin
    if (res_bits < RES_MIN) begin
      bits = RES_MIN;
    end else if (res_bits > RES_MAX) begin
      bits = RES_MAX;
    end else begin
      bits = res_bits;
    end
  end

  // duty * (2^bits - 1) written as a shift and a subtraction.
  assign scaled    = (SCALE_W'(duty) << bits) - SCALE_W'(duty);
  assign prod      = {{DIV100_W{1'b0}}, scaled} * {{SCALE_W{1'b0}}, DIV100_MUL};
  assign pwm_level = prod[DIV100_SHIFT +: PWM_W];

endmodule

// ===== sv/fan_duty_command_parser_with_failsafe_core.sv =====
// Fan duty command parser with failsafe. Each input transfer is either one
// packet byte (tuser low, tdata the byte, tlast on the final byte) or a
// one-millisecond tick (tuser high), and every input transfer yields exactly
// one output transfer carrying the applied duty, its PWM level, the failsafe
// flag and an event code. Items flow through an input register and a result
// register, so one transfer per cycle is sustained while m_axis_tready stays
// high; the parse, the timeout check and the constant division of the PWM
// scaling all complete in the single step between those registers.
module fan_duty_command_parser_with_failsafe_core import fdc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // packet_byte
  input  logic                 s_axis_tlast,
  input  logic                 s_axis_tuser,   // req_type
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // duty_percent[6:0], pwm_level[22:7], failsafe_on[23], event_code[25:24], zero fill
  output logic [OUT_W-1:0]     m_axis_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [RES_W-1:0]     res_bits;
  logic [TIMEOUT_W-1:0] timeout;

  logic       in_valid;
  logic       in_req;
  logic [7:0] in_byte;
  logic       in_last;
  logic       adv;

  fdc_status_t       status;
  logic [PWM_W-1:0]  pwm_next;

  logic              out_valid;
  logic [DUTY_W-1:0] out_duty;
  logic [PWM_W-1:0]  out_pwm;
  logic              out_fs;
  fdc_evt_t          out_evt;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_bits <= RES_RESET;
      timeout  <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PWM_BITS: res_bits <= cfg_data[RES_W-1:0];
        CFG_TIMEOUT:  timeout  <= cfg_data[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv           = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req  <= s_axis_tuser;
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  fdc_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .en          (adv),
    .req_type    (in_req),
    .packet_byte (in_byte),
    .last_byte   (in_last),
    .timeout     (timeout),
    .status      (status)
  );

  fdc_scale u_scale (
    .duty      (status.duty),
    .res_bits  (res_bits),
    .pwm_level (pwm_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_duty <= status.duty;
      out_pwm  <= pwm_next;
      out_fs   <= status.failsafe;
      out_evt  <= status.evt;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b000000, out_evt, out_fs, out_pwm, out_duty};

`ifndef SYNTHESIS
  a_trip_flag: assert property (@(posedge clk) disable iff (rst)
      out_valid && out_evt == EVT_FAILSAFE |-> out_fs)
    else $error("Failsafe event reported without the failsafe flag.");
  a_accept_flag: assert property (@(posedge clk) disable iff (rst)
      out_valid && out_evt == EVT_ACCEPT |-> !out_fs)
    else $error("Accepted packet reported while failsafe is still set.");
  a_fs_output: assert property (@(posedge clk) disable iff (rst)
      out_valid && out_fs |-> out_duty == '0 && out_pwm == '0)
    else $error("Fan is not stopped while failsafe is reported.");
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> out_duty <= DUTY_MAX)
    else $error("Reported duty exceeds full scale.");
`endif

endmodule
